// File: rtl/pkt_line_deframer_core_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef PKT_LINE_DEFRAMER_CORE_DEFINES_SVH
`define PKT_LINE_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PLD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pkt_line_deframer: assertion failed");

// Next-cycle implication, checked outside reset.
`define PLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pkt_line_deframer: assertion failed");

`endif

// File: rtl/pld_pkg.sv
package pld_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned KindW = 3;

  localparam logic [LenW-1:0] HdrDigits  = 16'd4;
  localparam logic [LenW-1:0] MinLong    = 16'd9;
  localparam logic [LenW-1:0] BadSpecial = 16'd3;
  localparam logic [3:0]      VersionLen = 4'd8;
  localparam logic [3:0]      VersionPos = 4'd8;
  localparam logic [3:0]      IndexHold  = 4'd9;

  // byte_kind codes
  localparam logic [KindW-1:0] KIND_DIGIT     = 3'd0;
  localparam logic [KindW-1:0] KIND_SPECIAL   = 3'd1;
  localparam logic [KindW-1:0] KIND_SIDEBAND  = 3'd2;
  localparam logic [KindW-1:0] KIND_PAYLOAD   = 3'd3;
  localparam logic [KindW-1:0] KIND_MALFORMED = 3'd4;
  localparam logic [KindW-1:0] KIND_DISCARD   = 3'd5;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_DISCARD = 3'b100
  } phase_t;

  typedef struct packed {
    logic [KindW-1:0] byte_kind;
    logic [LenW-1:0]  pkt_length;
    logic [1:0]       special_type;
    logic             bad_special;
    logic [1:0]       sb_channel;
    logic             version_valid;
    logic [ByteW-1:0] version_char;
    logic             line_end;
  } result_t;

  typedef struct packed {
    logic             ok;
    logic [3:0]       val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // "version " prefix, one character per position
  function automatic logic [ByteW-1:0] version_text(input logic [2:0] idx);
    logic [ByteW-1:0] c;
    case (idx)
      3'd0:    c = 8'h76;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h73;
      3'd4:    c = 8'h69;
      3'd5:    c = 8'h6f;
      3'd6:    c = 8'h6e;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/pld_parser.sv
module pld_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic [pld_pkg::ByteW-1:0]         in_byte,
  input  logic                              buffer_start,
  output pld_pkg::result_t                  res
);

  pld_pkg::phase_t            phase, phase_next;
  logic [1:0]                 digit_count, digit_count_next;
  logic [pld_pkg::LenW-1:0]   length_accum, length_accum_next;
  logic [pld_pkg::LenW-1:0]   bytes_left, bytes_left_next;
  logic [3:0]                 payload_index, payload_index_next;
  logic                       prefix_match, prefix_match_next;
  logic                       payload_long, payload_long_next;

  pld_pkg::phase_t            cur_phase;
  logic [1:0]                 cur_count;
  logic [pld_pkg::LenW-1:0]   cur_accum;
  pld_pkg::hex_t              hex;
  logic [pld_pkg::LenW-1:0]   accum_new;
  logic [1:0]                 count_new;
  logic [pld_pkg::LenW-1:0]   left_dec;
  logic [pld_pkg::LenW-1:0]   body_len;

  always_comb begin
    // a buffer start drops any partial line
    cur_phase = buffer_start ? pld_pkg::PH_HEADER : phase;
    cur_count = buffer_start ? 2'd0 : digit_count;
    cur_accum = buffer_start ? '0 : length_accum;

    hex       = pld_pkg::hex_decode(in_byte);
    accum_new = {cur_accum[pld_pkg::LenW-5:0], hex.val};
    count_new = cur_count + 2'd1;
    left_dec  = bytes_left - 16'd1;
    body_len  = accum_new - pld_pkg::HdrDigits;

    phase_next         = cur_phase;
    digit_count_next   = cur_count;
    length_accum_next  = cur_accum;
    bytes_left_next    = bytes_left;
    payload_index_next = payload_index;
    prefix_match_next  = prefix_match;
    payload_long_next  = payload_long;
    res                = '0;

    unique case (cur_phase)
      pld_pkg::PH_DISCARD: begin
        res.byte_kind = pld_pkg::KIND_DISCARD;
      end
      pld_pkg::PH_PAYLOAD: begin
        if (payload_index == 4'd0 && in_byte >= 8'd1 && in_byte <= 8'd3) begin
          res.byte_kind  = pld_pkg::KIND_SIDEBAND;
          res.sb_channel = in_byte[1:0];
        end else begin
          res.byte_kind = pld_pkg::KIND_PAYLOAD;
        end
        if (payload_index < pld_pkg::VersionLen) begin
          if (in_byte != pld_pkg::version_text(payload_index[2:0])) begin
            prefix_match_next = 1'b0;
          end
        end else if (payload_index == pld_pkg::VersionPos && prefix_match && payload_long) begin
          res.version_valid = 1'b1;
          res.version_char  = in_byte;
        end
        if (payload_index < pld_pkg::IndexHold) begin
          payload_index_next = payload_index + 4'd1;
        end
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          res.line_end      = 1'b1;
          phase_next        = pld_pkg::PH_HEADER;
          digit_count_next  = 2'd0;
          length_accum_next = '0;
        end
      end
      default: begin
        if (!hex.ok) begin
          res.byte_kind     = pld_pkg::KIND_MALFORMED;
          phase_next        = pld_pkg::PH_DISCARD;
          digit_count_next  = 2'd0;
          length_accum_next = '0;
        end else if (count_new != 2'd0) begin
          res.byte_kind     = pld_pkg::KIND_DIGIT;
          digit_count_next  = count_new;
          length_accum_next = accum_new;
        end else begin
          res.pkt_length    = accum_new;
          digit_count_next  = 2'd0;
          length_accum_next = '0;
          if (accum_new < pld_pkg::HdrDigits) begin
            res.byte_kind    = pld_pkg::KIND_SPECIAL;
            res.special_type = accum_new[1:0];
            res.bad_special  = (accum_new == pld_pkg::BadSpecial);
            res.line_end     = 1'b1;
            phase_next       = pld_pkg::PH_HEADER;
          end else begin
            res.byte_kind   = pld_pkg::KIND_DIGIT;
            bytes_left_next = body_len;
            if (body_len == '0) begin
              res.line_end = 1'b1;
              phase_next   = pld_pkg::PH_HEADER;
            end else begin
              phase_next         = pld_pkg::PH_PAYLOAD;
              payload_index_next = 4'd0;
              prefix_match_next  = 1'b1;
              payload_long_next  = (body_len >= pld_pkg::MinLong);
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= pld_pkg::PH_HEADER;
      digit_count   <= 2'd0;
      length_accum  <= '0;
      bytes_left    <= '0;
      payload_index <= 4'd0;
      prefix_match  <= 1'b1;
      payload_long  <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      digit_count   <= digit_count_next;
      length_accum  <= length_accum_next;
      bytes_left    <= bytes_left_next;
      payload_index <= payload_index_next;
      prefix_match  <= prefix_match_next;
      payload_long  <= payload_long_next;
    end
  end

endmodule

// File: rtl/pkt_line_deframer_core.sv
// Line deframer for length-prefixed text lines (four hex digit header).
// Input: s_tvalid/s_tready/s_tdata/s_tuser, one raw byte per transfer;
//   s_tuser set on the first byte of a new buffer restarts the parser.
// Output: m_tvalid/m_tready/m_tdata/m_tuser/m_tlast, exactly one result
//   transfer per input transfer, in order. m_tuser is the byte kind,
//   m_tlast marks the last byte of a line.
// Path: an accepted byte waits in the input holding register and moves
//   through the parser into the result register when the output is free.
// Throughput: one byte per cycle while m_tready is high. All per-byte work
//   is a single pass of logic between the input holding register and the
//   result register; parser state updates in the same cycle as its result.
// Stalls: while m_tready is low the result register holds, the input
//   register takes one more byte, and s_tready then drops until the
//   result is taken.
// Reset: rst (synchronous) empties both registers and returns the parser
//   to the header phase; no clearing time is needed.
`include "pkt_line_deframer_core_defines.svh"

module pkt_line_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] buffer_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] pkt_length, [17:16] special_type,
                                 // [18] bad_special, [20:19] sb_channel,
                                 // [21] version_valid, [29:22] version_char,
                                 // [31:30] zero
  output logic [2:0]  m_tuser,   // [2:0] byte_kind
  output logic        m_tlast    // line_end
);

  logic                       in_valid;
  logic [pld_pkg::ByteW-1:0]  in_byte;
  logic                       in_start;
  logic                       advance;
  pld_pkg::result_t           res;
  pld_pkg::result_t           out_res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  pld_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .in_byte      (in_byte),
    .buffer_start (in_start),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.version_char, out_res.version_valid,
                    out_res.sb_channel, out_res.bad_special,
                    out_res.special_type, out_res.pkt_length};
  assign m_tuser = out_res.byte_kind;
  assign m_tlast = out_res.line_end;

  `PLD_ASSERT_IMPL(a_special_ends_line, m_tvalid && m_tuser == pld_pkg::KIND_SPECIAL, m_tlast)
  `PLD_ASSERT_IMPL(a_version_on_payload, m_tvalid && m_tdata[21], m_tuser == pld_pkg::KIND_PAYLOAD)
  `PLD_ASSERT_IMPL(a_bad_special_code, m_tvalid && m_tdata[18], m_tdata[17:16] == 2'd3)
  `PLD_ASSERT_NEXT(a_stalled_byte_kept, in_valid && !advance, in_valid)

endmodule

// File: test/pkt_line_deframer_core_tb.sv
`timescale 1ns / 100ps

module pkt_line_deframer_core_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_ITEMS    = 520;
  localparam logic [63:0] VERSION_TAG = "version ";

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  stream_byte_t     byte_queue[$];
  pld_pkg::result_t expected_reports[$];

  // parser state as predicted
  pld_pkg::phase_t ph = pld_pkg::PH_HEADER;
  logic [1:0]  digits = '0;
  logic [15:0] len_acc = '0;
  logic [15:0] left = '0;
  logic [3:0]  pay_idx = '0;
  logic        prefix_ok = 1'b1;
  logic        pay_long = 1'b0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  bit in_taken = 1'b0;
  int idle_cycles = 0;
  int mismatches = 0;
  int kind_seen[6];
  int bad_seen = 0;
  int versions_seen = 0;
  int lines_seen = 0;
  int items_queued = 0;
  bit next_start = 1'b0;
  bit force_start = 1'b0;
  int target;

  pkt_line_deframer_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // {valid, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] version_byte(input int i);
    return VERSION_TAG[63 - 8*i -: 8];
  endfunction

  function automatic pld_pkg::result_t predict_report(input logic [7:0] b, input logic start);
    pld_pkg::result_t r;
    logic [4:0]       nib;
    r = '0;
    if (start) begin
      ph = pld_pkg::PH_HEADER;
      digits = '0;
      len_acc = '0;
    end
    case (ph)
      pld_pkg::PH_DISCARD: r.byte_kind = pld_pkg::KIND_DISCARD;
      pld_pkg::PH_PAYLOAD: begin
        if (pay_idx == 0 && b >= 8'd1 && b <= 8'd3) begin
          r.byte_kind = pld_pkg::KIND_SIDEBAND;
          r.sb_channel = b[1:0];
        end else begin
          r.byte_kind = pld_pkg::KIND_PAYLOAD;
        end
        if (pay_idx < 4'd8) begin
          if (b != version_byte(pay_idx)) prefix_ok = 1'b0;
        end else if (pay_idx == 4'd8 && prefix_ok && pay_long) begin
          r.version_valid = 1'b1;
          r.version_char = b;
        end
        if (pay_idx < 4'd9) pay_idx = pay_idx + 4'd1;
        left = left - 16'd1;
        if (left == 0) begin
          r.line_end = 1'b1;
          ph = pld_pkg::PH_HEADER;
          digits = '0;
          len_acc = '0;
        end
      end
      default: begin
        nib = hex_nibble(b);
        if (!nib[4]) begin
          r.byte_kind = pld_pkg::KIND_MALFORMED;
          ph = pld_pkg::PH_DISCARD;
          digits = '0;
          len_acc = '0;
        end else begin
          len_acc = {len_acc[11:0], nib[3:0]};
          digits = digits + 2'd1;
          r.byte_kind = pld_pkg::KIND_DIGIT;
          if (digits == 0) begin
            r.pkt_length = len_acc;
            if (len_acc < 16'd4) begin
              r.byte_kind = pld_pkg::KIND_SPECIAL;
              r.special_type = len_acc[1:0];
              r.bad_special = (len_acc == 16'd3);
              r.line_end = 1'b1;
              ph = pld_pkg::PH_HEADER;
              len_acc = '0;
            end else begin
              left = len_acc - 16'd4;
              len_acc = '0;
              if (left == 0) begin
                r.line_end = 1'b1;
                ph = pld_pkg::PH_HEADER;
              end else begin
                ph = pld_pkg::PH_PAYLOAD;
                pay_idx = '0;
                prefix_ok = 1'b1;
                pay_long = (left >= 16'd9);
              end
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // stimulus helpers
  task automatic push_byte(input logic [7:0] b, input logic start);
    byte_queue.push_back('{data: b, start: start | next_start});
    next_start = 1'b0;
    items_queued++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    if ($urandom_range(0, 1) == 0) return 8'("a") + 8'(n - 4'd10);
    return 8'("A") + 8'(n - 4'd10);
  endfunction

  task automatic push_header(input logic [15:0] v, input int ndig);
    for (int i = 0; i < ndig; i++) push_byte(hex_char(v[15 - 4*i -: 4]), 1'b0);
  endtask

  task automatic begin_line();
    next_start = force_start || ($urandom_range(0, 7) == 0);
    force_start = 1'b0;
  endtask

  task automatic queue_random_line();
    int         sel;
    int         plen;
    int         n;
    logic [7:0] b;
    sel = $urandom_range(0, 99);
    begin_line();
    if (sel < 14) begin
      push_header(16'($urandom_range(0, 3)), 4);
    end else if (sel < 20) begin
      push_header(16'd4, 4);
    end else if (sel < 38) begin
      plen = $urandom_range(9, 14);
      push_header(16'(plen + 4), 4);
      for (int i = 0; i < plen; i++) begin
        b = (i < 8) ? version_byte(i) : 8'($urandom);
        if (i < 8 && $urandom_range(0, 9) == 0) b = 8'($urandom);
        push_byte(b, 1'b0);
      end
    end else if (sel < 52) begin
      plen = $urandom_range(1, 12);
      push_header(16'(plen + 4), 4);
      push_byte(8'($urandom_range(1, 3)), 1'b0);
      for (int i = 1; i < plen; i++) push_byte(8'($urandom), 1'b0);
    end else if (sel < 80) begin
      plen = $urandom_range(1, 24);
      n = $urandom_range(0, 2);
      push_header(16'(plen + 4), 4);
      for (int i = 0; i < plen; i++) begin
        if (n == 0 && i < 8) b = version_byte(i);
        else if (n == 1) b = 8'($urandom_range(32, 126));
        else b = 8'($urandom);
        push_byte(b, 1'b0);
      end
    end else if (sel < 88) begin
      // cut short by the next buffer start
      push_header(16'($urandom), $urandom_range(1, 4));
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) push_byte(8'($urandom), 1'b0);
      force_start = 1'b1;
    end else if (sel < 95) begin
      push_header(16'($urandom), $urandom_range(0, 3));
      do b = 8'($urandom); while (hex_nibble(b) != 5'd0 && b != 8'h00);
      if (hex_nibble(b) != 5'd0) b = 8'h20;
      push_byte(b, 1'b0);
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) push_byte(8'($urandom), 1'b0);
      force_start = 1'b1;
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) push_byte(8'($urandom), 1'($urandom_range(0, 1)));
      force_start = 1'b1;
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || s_tvalid || expected_reports.size() != 0)
      @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin : drive
    stream_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (byte_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = byte_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= nxt.data;
        s_tuser <= nxt.start;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // prediction on input transfers, checking on output transfers
  always @(posedge clk) begin : monitor
    pld_pkg::result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) expected_reports.push_back(predict_report(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        if (m_tuser < 3'd6) kind_seen[m_tuser]++;
        bad_seen += m_tdata[18];
        versions_seen += m_tdata[21];
        lines_seen += m_tlast;
        if (expected_reports.size() == 0) begin
          $error("unexpected byte report: kind %0d, data 0x%08h", m_tuser, m_tdata);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("byte_kind", want.byte_kind, m_tuser);
          compare_field("pkt_length", want.pkt_length, m_tdata[15:0]);
          compare_field("special_type", want.special_type, m_tdata[17:16]);
          compare_field("bad_special", want.bad_special, m_tdata[18]);
          compare_field("sb_channel", want.sb_channel, m_tdata[20:19]);
          compare_field("version_valid", want.version_valid, m_tdata[21]);
          compare_field("version_char", want.version_char, m_tdata[29:22]);
          compare_field("line_end", want.line_end, m_tlast);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: bad special, zero-length line, version line, sideband,
    // malformed byte and discard
    tx_idle_pct = 12;
    rx_idle_pct = 82;
    next_start = 1'b1;
    push_header(16'd3, 4);
    push_header(16'd4, 4);
    push_header(16'h000d, 4);
    for (int i = 0; i < 8; i++) push_byte(version_byte(i), 1'b0);
    push_byte("2", 1'b0);
    push_header(16'd5, 4);
    push_byte(8'h03, 1'b0);
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b0);
    force_start = 1'b1;
    wait_drained();

    target = items_queued + PHASE_ITEMS;
    while (items_queued < target) queue_random_line();
    wait_drained();

    tx_idle_pct = 82;
    rx_idle_pct = 12;
    target = items_queued + PHASE_ITEMS;
    while (items_queued < target) queue_random_line();
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    target = items_queued + PHASE_ITEMS;
    while (items_queued < target) queue_random_line();
    wait_drained();

    // receiver stalls while the sender keeps offering
    hold_armed = 1'b1;
    target = items_queued + 120;
    while (items_queued < target) queue_random_line();
    wait_drained();

    repeat (8) @(posedge clk);
    $write("%0d bytes sent; kinds digit/special/sideband/payload/malformed/discard: ",
           items_queued);
    $display("%0d/%0d/%0d/%0d/%0d/%0d", kind_seen[0], kind_seen[1], kind_seen[2],
             kind_seen[3], kind_seen[4], kind_seen[5]);
    $display("%0d line ends, %0d bad specials, %0d version reports, long output stall done",
             lines_seen, bad_seen, versions_seen);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pld_pkg.sv
rtl/pld_parser.sv
rtl/pkt_line_deframer_core.sv
test/pkt_line_deframer_core_tb.sv
